// File: sv/rkbs_pkg.sv
package rkbs_pkg;

  localparam int MAX_ROWS = 16;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 4;
  localparam int IDX_W    = $clog2(MAX_ROWS);
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);

  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS,
    S_FIRST,
    S_CMP,
    S_TAIL,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_HOLD
  } state_t;

endpackage

// File: sv/rkbs_if.sv
interface rkbs_in_if;
  import rkbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] row_key;
  logic                    final_row;
  modport source (output valid, output row_key, output final_row, input ready);
  modport sink   (input valid, input row_key, input final_row, output ready);
endinterface

interface rkbs_out_if;
  import rkbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TAG_W-1:0]        source_row;
  logic signed [KEY_W-1:0] sorted_key;
  logic                    end_of_set;
  logic                    overflowed;
  modport source (output valid, output source_row, output sorted_key, output end_of_set,
                  output overflowed, input ready);
  modport sink   (input valid, input source_row, input sorted_key, input end_of_set,
                  input overflowed, output ready);
endinterface

// File: sv/rkbs_cmp_unit.sv
module rkbs_cmp_unit
  import rkbs_pkg::*;
(
  input  entry_t carry,
  input  entry_t nxt,
  output entry_t wr_entry,
  output entry_t carry_next
);

  logic lt;

  // smaller key keeps bubbling right; ties leave the carried row behind
  assign lt = carry.key < nxt.key;

  always_comb begin
    if (lt) begin
      wr_entry   = nxt;
      carry_next = carry;
    end else begin
      wr_entry   = carry;
      carry_next = nxt;
    end
  end

endmodule

// File: sv/row_key_bubble_sorter_top.sv
// Loading: one key beat per cycle, no result until the final-row beat.
// Sort: for n stored rows, one compare per cycle through a single shared
// compare unit on a one-read one-write store.
// Emission: each result beat is read, loaded and held until the sink takes it; input is held off.
// Reset (rst, synchronous): state, row count and overflow flag cleared; the
// key store holds no valid bits and needs no clearing pass.
module row_key_bubble_sorter_top
  import rkbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rkbs_in_if.sink     rows,
  rkbs_out_if.source  sorted
);

  state_t state, state_next;

  logic [CNT_W-1:0] rows_loaded;
  logic             overflow_seen;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] set_last;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] emit_idx;
  entry_t           carry;
  entry_t           out_entry;
  logic             out_end;
  logic             out_ovf;

  entry_t           mem [MAX_ROWS];
  entry_t           rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  entry_t cmp_wr;
  entry_t cmp_carry;

  logic in_beat, out_beat, has_room;

  assign in_beat  = rows.valid && rows.ready;
  assign out_beat = sorted.valid && sorted.ready;
  assign has_room = rows_loaded < CNT_W'(MAX_ROWS);

  rkbs_cmp_unit u_cmp (
    .carry      (carry),
    .nxt        (rdata),
    .wr_entry   (cmp_wr),
    .carry_next (cmp_carry)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_beat && rows.final_row) state_next = S_PASS;
      end
      S_PASS: begin
        if (last_idx == '0) state_next = S_EMIT_RD;
        else                state_next = S_FIRST;
      end
      S_FIRST: state_next = S_CMP;
      S_CMP: begin
        if (pos + IDX_W'(1) == last_idx) state_next = S_TAIL;
      end
      S_TAIL:    state_next = S_PASS;
      S_EMIT_RD: state_next = S_EMIT_LD;
      S_EMIT_LD: state_next = S_EMIT_HOLD;
      S_EMIT_HOLD: begin
        if (out_beat) begin
          if (out_end) state_next = S_LOAD;
          else         state_next = S_EMIT_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    rows.ready   = 1'b0;
    sorted.valid = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = pos;
    mem_wdata    = cmp_wr;
    mem_raddr    = '0;
    unique case (state)
      S_LOAD: begin
        // ready is always high here, so valid alone marks the beat
        rows.ready = 1'b1;
        mem_we     = rows.valid && has_room;
        mem_waddr  = rows_loaded[IDX_W-1:0];
        mem_wdata  = '{tag: TAG_W'(rows_loaded), key: rows.row_key};
      end
      S_PASS:  mem_raddr = '0;
      S_FIRST: mem_raddr = pos + IDX_W'(1);
      S_CMP: begin
        mem_we    = 1'b1;
        mem_raddr = pos + IDX_W'(2);
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = last_idx;
        mem_wdata = carry;
      end
      S_EMIT_RD:   mem_raddr = emit_idx;
      S_EMIT_LD:   mem_raddr = emit_idx;
      S_EMIT_HOLD: sorted.valid = 1'b1;
      default: ;
    endcase
  end

  assign sorted.source_row = out_entry.tag;
  assign sorted.sorted_key = out_entry.key;
  assign sorted.end_of_set = out_end;
  assign sorted.overflowed = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      rows_loaded   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (in_beat) begin
        if (has_room) rows_loaded <= rows_loaded + CNT_W'(1);
        else          overflow_seen <= 1'b1;
      end
      if (out_beat && out_end) begin
        rows_loaded   <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        if (has_room) begin
          last_idx <= rows_loaded[IDX_W-1:0];
          set_last <= rows_loaded[IDX_W-1:0];
        end else begin
          last_idx <= IDX_W'(MAX_ROWS - 1);
          set_last <= IDX_W'(MAX_ROWS - 1);
        end
        emit_idx <= '0;
      end
      S_PASS: pos <= '0;
      S_FIRST: carry <= rdata;
      S_CMP: begin
        carry <= cmp_carry;
        pos   <= pos + IDX_W'(1);
      end
      S_TAIL: last_idx <= last_idx - IDX_W'(1);
      S_EMIT_LD: begin
        out_entry <= rdata;
        out_end   <= emit_idx == set_last;
        out_ovf   <= overflow_seen;
      end
      S_EMIT_HOLD: begin
        if (out_beat) emit_idx <= emit_idx + IDX_W'(1);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rows_loaded <= CNT_W'(MAX_ROWS))
    else $error("row count beyond capacity");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> pos < last_idx)
    else $error("compare position past end of pass");

  a_set_closes: assert property (@(posedge clk) disable iff (rst)
    out_beat && sorted.end_of_set |=> rows_loaded == '0 && !overflow_seen && rows.ready)
    else $error("set not closed after last beat");

  a_no_load_mid_set: assert property (@(posedge clk) disable iff (rst)
    out_beat && !sorted.end_of_set |=> !rows.ready)
    else $error("input taken during emission");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    sorted.valid |-> emit_idx <= set_last)
    else $error("emission beyond stored rows");
`endif

endmodule
